// ----- hw/rtl/lobm_pkg.sv -----
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

    localparam int IDX_W_MAX = 16;
    localparam int GRP_BITS  = 16;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;

    typedef enum logic [2:0] {
        ST_RESTING       = 3'd0,
        ST_FILLED        = 3'd1,
        ST_POOL_FULL     = 3'd2,
        ST_CANCELLED     = 3'd3,
        ST_CANCEL_UNUSED = 3'd4
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [63:0] new_order_id;
        logic [63:0] client_ident;
        logic [31:0] quantity;
        logic [7:0]  price_tick;
        logic        buy_side;
        logic        market_order;
        logic [7:0]  cancel_slot;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot_handle;
        logic [63:0] echo_order_id;
        logic [31:0] filled_quantity;
        logic [31:0] remaining_quantity;
    } t_out_item;

    typedef struct packed {
        logic                 is_cancel;
        logic                 cancel_ok;
        logic [63:0]          ord_ident;
        logic [31:0]          quantity;
        logic [IDX_W_MAX-1:0] price;
        logic                 buy;
        logic                 market;
        logic [7:0]           cancel_slot;
        logic [IDX_W_MAX-1:0] cancel_idx;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_G,
        S_ALLOC_B,
        S_BEST_G,
        S_BEST_B,
        S_HEAD,
        S_TAKE,
        S_REST,
        S_APPEND,
        S_CAN_LVL,
        S_CAN_UNL,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/limit_order_book_matcher.sv -----
// Top level of the limit order book matcher: front queue and back-end sequencer.
// The back end works on one item at a time: it pops no new command from the queue until the
// result of the last one has been registered for output. An add walks the resting orders through
// the slot and level RAMs, one best level and head order per match step; a cancel of an unused
// slot goes straight to its result.
// Reset: synchronous active low; clears live-slot and level bitmaps, queue, FSM and output valid only.
module limit_order_book_matcher #(
    parameter int POOL_SLOTS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lobm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lobm_pkg::t_out_item o_out_item
);

    logic           w_cmd_valid;
    lobm_pkg::t_cmd w_cmd;
    logic           w_pop;

    lobm_front #(.POOL_SLOTS(POOL_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_pop   (w_pop)
    );

    lobm_back #(.POOL_SLOTS(POOL_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

// ----- hw/rtl/lobm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lobm_front.sv -----
// Front end: accepts items, classifies them and queues commands for the back end.
module lobm_front #(
    parameter int POOL_SLOTS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lobm_pkg::t_in_item  i_item,
    output logic                o_valid,
    output lobm_pkg::t_cmd      o_cmd,
    input  logic                i_pop
);

    lobm_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    lobm_pkg::t_cmd w_cmd;
    logic [31:0]    w_price_ext;
    logic [31:0]    w_price_sat;
    logic [31:0]    w_slot_ext;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_price_ext = {24'd0, i_item.price_tick};
        w_slot_ext  = {24'd0, i_item.cancel_slot};
        w_price_sat = (w_price_ext >= 32'(PRICE_LEVELS)) ? 32'(PRICE_LEVELS - 1) : w_price_ext;
        w_cmd.is_cancel   = (i_item.kind == lobm_pkg::KIND_CANCEL);
        w_cmd.cancel_ok   = (w_slot_ext < 32'(POOL_SLOTS));
        w_cmd.ord_ident   = i_item.new_order_id;
        w_cmd.quantity    = i_item.quantity;
        w_cmd.price       = w_price_sat[lobm_pkg::IDX_W_MAX-1:0];
        w_cmd.buy         = i_item.buy_side;
        w_cmd.market      = i_item.market_order;
        w_cmd.cancel_slot = i_item.cancel_slot;
        w_cmd.cancel_idx  = w_slot_ext[lobm_pkg::IDX_W_MAX-1:0];
    end

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- hw/rtl/lobm_back.sv -----
// Back end: slot allocation, level matching, resting, cancel and result register.
module lobm_back #(
    parameter int POOL_SLOTS   = 256,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  lobm_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output lobm_pkg::t_out_item o_item
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int LVL_W  = $clog2(PRICE_LEVELS);
    localparam int GB     = lobm_pkg::GRP_BITS;
    localparam int SGRP_N = (POOL_SLOTS + GB - 1) / GB;
    localparam int LGRP_N = (PRICE_LEVELS + GB - 1) / GB;
    localparam int SGRP_W = (SGRP_N > 1) ? $clog2(SGRP_N) : 1;
    localparam int LGRP_W = (LGRP_N > 1) ? $clog2(LGRP_N) : 1;

    lobm_pkg::t_state    r_state, n_state;
    logic [POOL_SLOTS-1:0]   r_live, n_live;
    logic [PRICE_LEVELS-1:0] r_bid_ne, n_bid_ne;
    logic [PRICE_LEVELS-1:0] r_ask_ne, n_ask_ne;
    lobm_pkg::t_cmd      r_cmd, n_cmd;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [31:0]         r_filled, n_filled;
    logic [SGRP_W-1:0]   r_sgrp, n_sgrp;
    logic [LGRP_W-1:0]   r_lgrp, n_lgrp;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_tail, n_tail;
    logic [63:0]         r_cid, n_cid;
    logic [31:0]         r_cqty, n_cqty;
    logic [SLOT_W-1:0]   r_cnext, n_cnext;
    logic [SLOT_W-1:0]   r_cprev, n_cprev;
    logic                r_cbuy, n_cbuy;
    lobm_pkg::t_out_item r_res, n_res;
    lobm_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                     id_we, qty_we, meta_we, nxt_we, prv_we, lv_we;
    logic [SLOT_W-1:0]        id_waddr, qty_waddr, meta_waddr, nxt_waddr, prv_waddr;
    logic [SLOT_W-1:0]        id_raddr, qty_raddr, meta_raddr, nxt_raddr, prv_raddr;
    logic [LVL_W:0]           lv_waddr, lv_raddr;
    logic [63:0]              id_wdata, id_rdata;
    logic [31:0]              qty_wdata, qty_rdata;
    logic [LVL_W:0]           meta_wdata, meta_rdata;
    logic [SLOT_W-1:0]        nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
    logic [2*SLOT_W-1:0]      lv_wdata, lv_rdata;

    logic [SGRP_N*GB-1:0]     w_free_pad;
    logic [LGRP_N*GB-1:0]     w_lvl_pad;
    logic [SGRP_N-1:0]        w_sgrp_any;
    logic [LGRP_N-1:0]        w_lgrp_any;
    logic [GB-1:0]            w_sbits, w_lbits;
    logic [SLOT_W-1:0]        w_spick;
    logic [LVL_W-1:0]         w_lpick;
    logic [3:0]               w_lbit;
    logic [LVL_W-1:0]         w_price;
    logic [SLOT_W-1:0]        w_cidx;
    logic                     w_cancel_hit;
    logic                     w_bound_ok;
    logic [SLOT_W-1:0]        w_lv_head, w_lv_tail;
    logic [31:0]              w_need, w_take, w_left;
    logic                     w_rest_ne;
    logic                     w_can_ne;
    logic                     w_out_free;

    function automatic logic [3:0] f_low16(input logic [GB-1:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = GB - 1; i >= 0; i--) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [3:0] f_high16(input logic [GB-1:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < GB; i++) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [SGRP_W-1:0] f_low_s(input logic [SGRP_N-1:0] v);
        logic [SGRP_W-1:0] r;
        r = '0;
        for (int i = SGRP_N - 1; i >= 0; i--) begin
            if (v[i]) r = SGRP_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LGRP_W-1:0] f_low_l(input logic [LGRP_N-1:0] v);
        logic [LGRP_W-1:0] r;
        r = '0;
        for (int i = LGRP_N - 1; i >= 0; i--) begin
            if (v[i]) r = LGRP_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LGRP_W-1:0] f_high_l(input logic [LGRP_N-1:0] v);
        logic [LGRP_W-1:0] r;
        r = '0;
        for (int i = 0; i < LGRP_N; i++) begin
            if (v[i]) r = LGRP_W'(i);
        end
        return r;
    endfunction

    always_comb begin
        w_free_pad = '0;
        w_free_pad[POOL_SLOTS-1:0] = ~r_live;
        w_lvl_pad = '0;
        w_lvl_pad[PRICE_LEVELS-1:0] = r_cmd.buy ? r_ask_ne : r_bid_ne;
        for (int g = 0; g < SGRP_N; g++) begin
            w_sgrp_any[g] = |w_free_pad[g*GB +: GB];
        end
        for (int g = 0; g < LGRP_N; g++) begin
            w_lgrp_any[g] = |w_lvl_pad[g*GB +: GB];
        end
    end

    assign w_sbits   = w_free_pad[r_sgrp*GB +: GB];
    assign w_spick   = SLOT_W'({r_sgrp, f_low16(w_sbits)});
    assign w_lbits   = w_lvl_pad[r_lgrp*GB +: GB];
    assign w_lbit    = r_cmd.buy ? f_low16(w_lbits) : f_high16(w_lbits);
    assign w_lpick   = LVL_W'({r_lgrp, w_lbit});
    assign w_price   = r_cmd.price[LVL_W-1:0];
    assign w_cidx    = i_cmd.cancel_idx[SLOT_W-1:0];
    assign w_cancel_hit = i_cmd.cancel_ok && r_live[w_cidx];
    assign w_bound_ok = r_cmd.market ||
                        (r_cmd.buy ? (w_lpick <= w_price) : (w_lpick >= w_price));
    assign w_lv_head = lv_rdata[2*SLOT_W-1:SLOT_W];
    assign w_lv_tail = lv_rdata[SLOT_W-1:0];
    assign w_need    = r_cmd.quantity - r_filled;
    assign w_take    = (qty_rdata < w_need) ? qty_rdata : w_need;
    assign w_left    = qty_rdata - w_take;
    assign w_rest_ne = r_cmd.buy ? r_bid_ne[w_price] : r_ask_ne[w_price];
    assign w_can_ne  = r_cbuy ? r_bid_ne[r_lvl] : r_ask_ne[r_lvl];
    assign w_out_free = !r_out_valid || !i_stall;

    lobm_ram #(.WIDTH(64), .DEPTH(POOL_SLOTS)) u_id_ram (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_waddr), .i_wdata(id_wdata),
        .i_raddr(id_raddr), .o_rdata(id_rdata)
    );
    lobm_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_qty_ram (
        .i_clk(i_clk), .i_we(qty_we), .i_waddr(qty_waddr), .i_wdata(qty_wdata),
        .i_raddr(qty_raddr), .o_rdata(qty_rdata)
    );
    lobm_ram #(.WIDTH(LVL_W + 1), .DEPTH(POOL_SLOTS)) u_meta_ram (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(meta_raddr), .o_rdata(meta_rdata)
    );
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_next_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rdata)
    );
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(prv_raddr), .o_rdata(prv_rdata)
    );
    lobm_ram #(.WIDTH(2 * SLOT_W), .DEPTH(2 * PRICE_LEVELS)) u_level_ram (
        .i_clk(i_clk), .i_we(lv_we), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_raddr(lv_raddr), .o_rdata(lv_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.is_cancel) begin
                        n_state = lobm_pkg::S_ALLOC_G;
                    end else if (w_cancel_hit) begin
                        n_state = lobm_pkg::S_CAN_LVL;
                    end else begin
                        n_state = lobm_pkg::S_DONE;
                    end
                end
            end
            lobm_pkg::S_ALLOC_G: n_state = (|w_sgrp_any) ? lobm_pkg::S_ALLOC_B : lobm_pkg::S_DONE;
            lobm_pkg::S_ALLOC_B: n_state = lobm_pkg::S_BEST_G;
            lobm_pkg::S_BEST_G: begin
                if (r_filled == r_cmd.quantity) begin
                    n_state = lobm_pkg::S_DONE;
                end else if (|w_lgrp_any) begin
                    n_state = lobm_pkg::S_BEST_B;
                end else begin
                    n_state = lobm_pkg::S_REST;
                end
            end
            lobm_pkg::S_BEST_B:  n_state = w_bound_ok ? lobm_pkg::S_HEAD : lobm_pkg::S_REST;
            lobm_pkg::S_HEAD:    n_state = lobm_pkg::S_TAKE;
            lobm_pkg::S_TAKE:    n_state = lobm_pkg::S_BEST_G;
            lobm_pkg::S_REST:    n_state = w_rest_ne ? lobm_pkg::S_APPEND : lobm_pkg::S_DONE;
            lobm_pkg::S_APPEND:  n_state = lobm_pkg::S_DONE;
            lobm_pkg::S_CAN_LVL: n_state = lobm_pkg::S_CAN_UNL;
            lobm_pkg::S_CAN_UNL: n_state = lobm_pkg::S_DONE;
            lobm_pkg::S_DONE:    n_state = w_out_free ? lobm_pkg::S_IDLE : lobm_pkg::S_DONE;
            default:             n_state = lobm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_live      = r_live;
        n_bid_ne    = r_bid_ne;
        n_ask_ne    = r_ask_ne;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_sgrp      = r_sgrp;
        n_lgrp      = r_lgrp;
        n_lvl       = r_lvl;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cid       = r_cid;
        n_cqty      = r_cqty;
        n_cnext     = r_cnext;
        n_cprev     = r_cprev;
        n_cbuy      = r_cbuy;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;

        id_we      = 1'b0;
        id_waddr   = r_slot;
        id_wdata   = r_cmd.ord_ident;
        id_raddr   = w_cidx;
        qty_we     = 1'b0;
        qty_waddr  = r_slot;
        qty_wdata  = w_need;
        qty_raddr  = w_cidx;
        meta_we    = 1'b0;
        meta_waddr = r_slot;
        meta_wdata = {w_price, r_cmd.buy};
        meta_raddr = w_cidx;
        nxt_we     = 1'b0;
        nxt_waddr  = w_lv_tail;
        nxt_wdata  = r_slot;
        nxt_raddr  = w_cidx;
        prv_we     = 1'b0;
        prv_waddr  = r_slot;
        prv_wdata  = w_lv_tail;
        prv_raddr  = w_cidx;
        lv_we      = 1'b0;
        lv_waddr   = {r_cmd.buy, w_price};
        lv_wdata   = {r_slot, r_slot};
        lv_raddr   = {r_cmd.buy, w_price};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_slot = w_cidx;
                    n_res.status             = lobm_pkg::ST_CANCEL_UNUSED;
                    n_res.slot_handle        = i_cmd.cancel_slot;
                    n_res.echo_order_id      = '0;
                    n_res.filled_quantity    = '0;
                    n_res.remaining_quantity = '0;
                    if (i_cmd.is_cancel && w_cancel_hit) begin
                        n_live[w_cidx] = 1'b0;
                    end
                end
            end
            lobm_pkg::S_ALLOC_G: begin
                n_sgrp = f_low_s(w_sgrp_any);
                n_res.status             = lobm_pkg::ST_POOL_FULL;
                n_res.slot_handle        = '0;
                n_res.echo_order_id      = r_cmd.ord_ident;
                n_res.filled_quantity    = '0;
                n_res.remaining_quantity = '0;
            end
            lobm_pkg::S_ALLOC_B: begin
                n_slot           = w_spick;
                n_live[w_spick]  = 1'b1;
                n_filled         = '0;
            end
            lobm_pkg::S_BEST_G: begin
                n_lgrp = r_cmd.buy ? f_low_l(w_lgrp_any) : f_high_l(w_lgrp_any);
                if (r_filled == r_cmd.quantity) begin
                    n_live[r_slot] = 1'b0;
                    n_res.status             = lobm_pkg::ST_FILLED;
                    n_res.slot_handle        = 8'(r_slot);
                    n_res.echo_order_id      = r_cmd.ord_ident;
                    n_res.filled_quantity    = r_filled;
                    n_res.remaining_quantity = '0;
                end
            end
            lobm_pkg::S_BEST_B: begin
                n_lvl    = w_lpick;
                lv_raddr = {~r_cmd.buy, w_lpick};
            end
            lobm_pkg::S_HEAD: begin
                n_head    = w_lv_head;
                n_tail    = w_lv_tail;
                qty_raddr = w_lv_head;
                nxt_raddr = w_lv_head;
            end
            lobm_pkg::S_TAKE: begin
                qty_we    = 1'b1;
                qty_waddr = r_head;
                qty_wdata = w_left;
                n_filled  = r_filled + w_take;
                if (w_left == 32'd0) begin
                    n_live[r_head] = 1'b0;
                    if (r_head == r_tail) begin
                        if (r_cmd.buy) begin
                            n_ask_ne[r_lvl] = 1'b0;
                        end else begin
                            n_bid_ne[r_lvl] = 1'b0;
                        end
                    end else begin
                        lv_we    = 1'b1;
                        lv_waddr = {~r_cmd.buy, r_lvl};
                        lv_wdata = {nxt_rdata, r_tail};
                    end
                end
            end
            lobm_pkg::S_REST: begin
                id_we   = 1'b1;
                qty_we  = 1'b1;
                meta_we = 1'b1;
                n_res.status             = lobm_pkg::ST_RESTING;
                n_res.slot_handle        = 8'(r_slot);
                n_res.echo_order_id      = r_cmd.ord_ident;
                n_res.filled_quantity    = r_filled;
                n_res.remaining_quantity = w_need;
                if (!w_rest_ne) begin
                    lv_we = 1'b1;
                    if (r_cmd.buy) begin
                        n_bid_ne[w_price] = 1'b1;
                    end else begin
                        n_ask_ne[w_price] = 1'b1;
                    end
                end
            end
            lobm_pkg::S_APPEND: begin
                nxt_we   = 1'b1;
                prv_we   = 1'b1;
                lv_we    = 1'b1;
                lv_wdata = {w_lv_head, r_slot};
            end
            lobm_pkg::S_CAN_LVL: begin
                n_cid    = id_rdata;
                n_cqty   = qty_rdata;
                n_cnext  = nxt_rdata;
                n_cprev  = prv_rdata;
                n_cbuy   = meta_rdata[0];
                n_lvl    = meta_rdata[LVL_W:1];
                lv_raddr = {meta_rdata[0], meta_rdata[LVL_W:1]};
            end
            lobm_pkg::S_CAN_UNL: begin
                lv_waddr = {r_cbuy, r_lvl};
                n_res.status             = lobm_pkg::ST_CANCELLED;
                n_res.slot_handle        = r_cmd.cancel_slot;
                n_res.echo_order_id      = r_cid;
                n_res.filled_quantity    = '0;
                n_res.remaining_quantity = r_cqty;
                if (w_can_ne) begin
                    if (r_slot == w_lv_head && r_slot == w_lv_tail) begin
                        if (r_cbuy) begin
                            n_bid_ne[r_lvl] = 1'b0;
                        end else begin
                            n_ask_ne[r_lvl] = 1'b0;
                        end
                    end else if (r_slot == w_lv_head) begin
                        lv_we    = 1'b1;
                        lv_wdata = {r_cnext, w_lv_tail};
                    end else if (r_slot == w_lv_tail) begin
                        lv_we    = 1'b1;
                        lv_wdata = {w_lv_head, r_cprev};
                    end else begin
                        nxt_we    = 1'b1;
                        nxt_waddr = r_cprev;
                        nxt_wdata = r_cnext;
                        prv_we    = 1'b1;
                        prv_waddr = r_cnext;
                        prv_wdata = r_cprev;
                    end
                end
            end
            lobm_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lobm_pkg::S_IDLE;
            r_live      <= '0;
            r_bid_ne    <= '0;
            r_ask_ne    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_bid_ne    <= n_bid_ne;
            r_ask_ne    <= n_ask_ne;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_slot   <= n_slot;
        r_filled <= n_filled;
        r_sgrp   <= n_sgrp;
        r_lgrp   <= n_lgrp;
        r_lvl    <= n_lvl;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_cid    <= n_cid;
        r_cqty   <= n_cqty;
        r_cnext  <= n_cnext;
        r_cprev  <= n_cprev;
        r_cbuy   <= n_cbuy;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_take_needs_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lobm_pkg::S_TAKE |-> r_filled < r_cmd.quantity)
        else $error("match step with nothing left to fill");

    a_alloc_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lobm_pkg::S_ALLOC_B |-> !r_live[w_spick])
        else $error("allocated slot is already live");

    a_best_level_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lobm_pkg::S_BEST_B |->
            (r_cmd.buy ? r_ask_ne[w_lpick] : r_bid_ne[w_lpick]))
        else $error("best level is empty");

    a_filled_no_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == lobm_pkg::ST_FILLED |-> r_out.remaining_quantity == '0)
        else $error("fully matched result with remaining units");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != lobm_pkg::S_IDLE)
        else $error("command taken without starting work");
`endif

endmodule
